/* src/gfau_pkg.sv */
// gfau_pkg: shared types, constants and the multiply digit step for the
// GF(2^8) / GF(2^32) arithmetic unit. No dependencies.
`default_nettype none

package gfau_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned NARROW_W = 8;
    // multiplier bits consumed per cycle
    localparam int unsigned DIGIT = 8;
    localparam int unsigned STEPS_WIDE = DATA_W / DIGIT;
    localparam int unsigned STEPS_NARROW = NARROW_W / DIGIT;
    localparam int unsigned CNT_W = (STEPS_WIDE > 1) ? $clog2(STEPS_WIDE) : 1;

    // reduction polynomials without the leading term
    localparam logic [NARROW_W-1:0] POLY8_LOW = 8'h1D;
    localparam logic [DATA_W-1:0] POLY32_LOW = 32'h0040_0007;

    // inverse exponents 2^m - 2
    localparam logic [DATA_W-1:0] INV_EXP8 = 32'd254;
    localparam logic [DATA_W-1:0] INV_EXP32 = 32'hFFFF_FFFE;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_INV = 2'd2;
    localparam logic [1:0] CMD_POW = 2'd3;

    typedef logic [DATA_W-1:0] t_word;

    typedef struct packed {
        logic start;
        logic wide;
    } t_mul_req;

    typedef struct packed {
        logic done;
    } t_mul_stat;

    typedef struct packed {
        t_word x;
        t_word acc;
    } t_mul_data;

    function automatic t_word field_mask(input t_word v, input logic wide);
        field_mask = wide ? v : {{(DATA_W-NARROW_W){1'b0}}, v[NARROW_W-1:0]};
    endfunction

    // multiply by x with reduction
    function automatic t_word xtime(input t_word v, input logic wide);
        t_word r;
        if (wide) begin
            r = {v[DATA_W-2:0], 1'b0} ^ (v[DATA_W-1] ? POLY32_LOW : '0);
        end else begin
            r = {{(DATA_W-NARROW_W){1'b0}}, v[NARROW_W-2:0], 1'b0}
                ^ (v[NARROW_W-1] ? {{(DATA_W-NARROW_W){1'b0}}, POLY8_LOW} : '0);
        end
        xtime = r;
    endfunction

    // one digit of shift-and-add: consumes the low DIGIT bits of y
    function automatic t_mul_data mul_digit(input t_word x, input t_word y,
                                            input t_word acc, input logic wide);
        t_mul_data d;
        d.x = x;
        d.acc = acc;
        for (int k = 0; k < DIGIT; k++) begin
            if (y[k]) begin
                d.acc = d.acc ^ d.x;
            end
            d.x = xtime(d.x, wide);
        end
        mul_digit = d;
    endfunction

endpackage

`default_nettype wire

/* src/gf2m_field_arith_unit.sv */
// Add: straight to S_DONE. Multiply: S digit steps (S = 4 in GF(2^32), 1 in GF(2^8)).
// Inverse/power: square-and-multiply from exponent bit 0 up, one acc * base product per
// set bit, a squaring per bit but the last set one, on the single digit-serial multiplier.
// Throughput: one word at a time; i_ready-side output register frees the input early.
// Reset: synchronous active-low i_rst_n clears sequencer state and output valid.
// Depends on gfau_pkg and gfau_mul.
`default_nettype none

module gf2m_field_arith_unit
    import gfau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input word
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic        i_wide,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    // result word
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_result
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;  // single multiply in flight
    localparam logic [2:0] S_CHK  = 3'd2;  // inspect next exponent bit
    localparam logic [2:0] S_PMUL = 3'd3;  // acc * base in flight
    localparam logic [2:0] S_PSQR = 3'd4;  // base * base in flight
    localparam logic [2:0] S_DONE = 3'd5;  // result ready for output register

    logic [2:0] r_state, n_state;
    logic       r_wide, n_wide;
    t_word      r_acc, n_acc;     // running power product
    t_word      r_base, n_base;   // repeated squares of a
    t_word      r_exp, n_exp;     // remaining exponent bits
    t_word      r_res, n_res;     // finished result
    logic       r_out_valid, n_out_valid;
    t_word      r_out, n_out;

    t_mul_req   mul_req;
    t_mul_stat  mul_stat;
    t_word      mul_x;
    t_word      mul_y;
    t_word      mul_prod;

    t_word      a_m;
    t_word      b_m;

    gfau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    assign a_m = field_mask(i_operand_a, i_wide);
    assign b_m = field_mask(i_operand_b, i_wide);
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_wide = r_wide;
        n_acc = r_acc;
        n_base = r_base;
        n_exp = r_exp;
        n_res = r_res;
        n_out = r_out;
        // output register drains independently of the sequencer
        n_out_valid = r_out_valid & ~i_ready;
        mul_req.start = 1'b0;
        mul_req.wide = r_wide;
        mul_x = r_acc;
        mul_y = r_base;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_wide = i_wide;
                    case (i_cmd)
                        CMD_ADD: begin
                            n_res = a_m ^ b_m;
                            n_state = S_DONE;
                        end
                        CMD_MUL: begin
                            mul_req.start = 1'b1;
                            mul_req.wide = i_wide;
                            mul_x = a_m;
                            mul_y = b_m;
                            n_state = S_MUL;
                        end
                        default: begin
                            // inverse uses a^(2^m-2); power uses the full raw exponent
                            if (i_cmd == CMD_INV) begin
                                n_exp = i_wide ? INV_EXP32 : INV_EXP8;
                            end else begin
                                n_exp = i_operand_b;
                            end
                            if (a_m == '0) begin
                                // zero to any power, inverse of zero: 0
                                n_res = '0;
                                n_state = S_DONE;
                            end else begin
                                n_acc = t_word'(1);
                                n_base = a_m;
                                n_state = S_CHK;
                            end
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (mul_stat.done) begin
                    n_res = mul_prod;
                    n_state = S_DONE;
                end
            end
            S_CHK: begin
                if (r_exp == '0) begin
                    n_res = r_acc;
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    mul_req.start = 1'b1;
                    mul_x = r_acc;
                    mul_y = r_base;
                    n_state = S_PMUL;
                end else begin
                    mul_req.start = 1'b1;
                    mul_x = r_base;
                    mul_y = r_base;
                    n_state = S_PSQR;
                end
            end
            S_PMUL: begin
                if (mul_stat.done) begin
                    n_acc = mul_prod;
                    if (r_exp[DATA_W-1:1] == '0) begin
                        // last set bit: the final squaring is not needed
                        n_res = mul_prod;
                        n_state = S_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        mul_x = r_base;
                        mul_y = r_base;
                        n_state = S_PSQR;
                    end
                end
            end
            S_PSQR: begin
                if (mul_stat.done) begin
                    n_base = mul_prod;
                    n_exp = r_exp >> 1;
                    n_state = S_CHK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_wide <= n_wide;
        r_acc <= n_acc;
        r_base <= n_base;
        r_exp <= n_exp;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

/* src/gfau_mul.sv */
// gfau_mul: iterative GF(2^8)/GF(2^32) multiplier, one digit per cycle.
// Depends on gfau_pkg.
`default_nettype none

module gfau_mul
    import gfau_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_mul_req  i_req,
    input  wire t_word     i_x,
    input  wire t_word     i_y,
    output t_mul_stat      o_stat,
    output t_word          o_prod
);

    t_word            r_x, n_x;
    t_word            r_y, n_y;
    t_word            r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_wide, n_wide;
    t_mul_data        step;

    assign step = mul_digit(r_x, r_y, r_acc, r_wide);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_wide = r_wide;
        if (i_req.start) begin
            n_x = field_mask(i_x, i_req.wide);
            n_y = field_mask(i_y, i_req.wide);
            n_acc = '0;
            n_wide = i_req.wide;
            n_cnt = i_req.wide ? CNT_W'(STEPS_WIDE - 1) : CNT_W'(STEPS_NARROW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_x = step.x;
            n_y = r_y >> DIGIT;
            n_acc = step.acc;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_wide <= n_wide;
    end

    assign o_stat.done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

/* verif/gf2m_field_arith_unit_tb.sv */
// Self-checking testbench for gf2m_field_arith_unit: add, multiply, inverse and
// power over GF(2^8) and GF(2^32), with handshake gaps on both sides.
// Depends on gfau_pkg and the RTL of gf2m_field_arith_unit.
module gf2m_field_arith_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gfau_pkg::*;

    // Cycle limit: the slowest word is a GF(2^32) power or inverse. Random
    // stalls lengthen each word. With about 1500 random words and the directed
    // ones, a run still stays well under this limit.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned RANDOM_WORDS = 1500;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned IDLE_PCT = 34;

    // Tracks the field results still owed by the block, and checks each
    // result word in order against them.
    class field_scoreboard;
        t_word       owed_q[$];
        int unsigned fail_count;
        int unsigned checked;
        int unsigned cmd_seen[4];
        int unsigned wide_seen;

        // Shift-and-add product, reduced by the field polynomial.
        function t_word gf_product(t_word x, t_word y, logic wide);
            t_word       mask;
            t_word       acc;
            logic        msb;
            int unsigned nbits;
            mask  = wide ? 32'hFFFF_FFFF : 32'h0000_00FF;
            nbits = wide ? 32 : 8;
            acc   = '0;
            x     = x & mask;
            y     = y & mask;
            for (int unsigned k = 0; k < nbits; k++) begin
                if (y[0]) begin
                    acc = acc ^ x;
                end
                msb = wide ? x[31] : x[7];
                x   = (x << 1) & mask;
                if (msb) begin
                    x = x ^ (wide ? POLY32_LOW : t_word'(POLY8_LOW));
                end
                y = y >> 1;
            end
            return acc & mask;
        endfunction

        // Square-and-multiply; zero to any power is zero, also for exponent 0.
        function t_word gf_power(t_word base, t_word expo, logic wide);
            t_word acc;
            acc = 32'd1;
            if (base == '0) begin
                return '0;
            end
            while (expo != '0) begin
                if (expo[0]) begin
                    acc = gf_product(acc, base, wide);
                end
                expo = expo >> 1;
                base = gf_product(base, base, wide);
            end
            return acc;
        endfunction

        function void note_word(logic [1:0] cmd, logic wide, t_word a, t_word b);
            t_word mask;
            t_word res;
            mask = wide ? 32'hFFFF_FFFF : 32'h0000_00FF;
            case (cmd)
                CMD_ADD: res = (a ^ b) & mask;
                CMD_MUL: res = gf_product(a & mask, b & mask, wide);
                CMD_INV: res = gf_power(a & mask, wide ? INV_EXP32 : INV_EXP8, wide);
                default: res = gf_power(a & mask, b, wide);   // exponent is all 32 bits
            endcase
            owed_q.push_back(res & mask);
            cmd_seen[cmd]++;
            if (wide) begin
                wide_seen++;
            end
        endfunction

        function void check_result(t_word got);
            t_word want;
            if (owed_q.size() == 0) begin
                $error("result word with nothing owed: result actual %h", got);
                fail_count++;
                return;
            end
            want = owed_q.pop_front();
            checked++;
            if (got !== want) begin
                $error("mismatch on result: expected %h actual %h", want, got);
                fail_count++;
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic        i_wide;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_result;

    field_scoreboard board;
    int unsigned     cycle_count;
    // set during the stretch where neither side idles
    logic            no_idle;

    gf2m_field_arith_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_wide      (i_wide),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side backpressure, changed at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Result words are taken at the rising edge that completes the handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result(o_result);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle limit %0d", CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Drive one word. Called at a falling edge and returns at a falling edge.
    // Random gaps drop valid first; once up, valid holds until the handshake.
    task automatic send_word(input logic [1:0] cmd, input logic wide,
                             input t_word a, input t_word b);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_wide      <= wide;
        i_operand_a <= a;
        i_operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        board.note_word(cmd, wide, a, b);
        @(negedge i_clk);
    endtask

    // Field operand for random words: zero, tiny values and all ones get extra weight.
    function automatic t_word pick_operand();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return '0;
        end else if (roll < 16) begin
            return t_word'($urandom_range(3));
        end else if (roll < 20) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom();
    endfunction

    // Exponent for power words: small, extreme or full random.
    function automatic t_word pick_exponent();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return t_word'($urandom_range(5));
        end else if (roll < 20) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom();
    endfunction

    initial begin
        logic [1:0] cmd;
        logic       wide;
        t_word      a;
        t_word      b;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_cmd       = CMD_ADD;
        i_wide      = 1'b0;
        i_operand_a = '0;
        i_operand_b = '0;
        no_idle     = 1'b0;
        cycle_count = 0;
        board       = new();

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, every op in both fields, narrow masking of
        // the upper operand bits, full 32-bit exponent in narrow mode, and the
        // zero cases of inverse and power.
        send_word(CMD_ADD, 1'b0, 32'hFFFF_FF00, 32'h1234_56FF);
        send_word(CMD_ADD, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_ADD, 1'b1, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
        send_word(CMD_MUL, 1'b0, 32'h0000_00FF, 32'h0000_00FF);
        send_word(CMD_MUL, 1'b0, 32'hABCD_EF80, 32'h1357_9B02);
        send_word(CMD_MUL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_MUL, 1'b1, 32'h8000_0000, 32'h0000_0002);
        send_word(CMD_MUL, 1'b1, 32'h0000_0000, 32'hDEAD_BEEF);
        send_word(CMD_INV, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_INV, 1'b1, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_INV, 1'b0, 32'hFFFF_FF01, 32'h0000_0000);
        send_word(CMD_INV, 1'b0, 32'h0000_00FF, 32'h0000_0000);
        send_word(CMD_INV, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_INV, 1'b1, 32'h0000_0002, 32'h0000_0000);
        send_word(CMD_POW, 1'b0, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_POW, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_POW, 1'b0, 32'h0000_0003, 32'h0000_0000);
        send_word(CMD_POW, 1'b1, 32'h1234_5678, 32'h0000_0000);
        send_word(CMD_POW, 1'b0, 32'hFFFF_FF03, 32'h8000_0100);
        send_word(CMD_POW, 1'b0, 32'h0000_0002, 32'hFFFF_FFFF);
        send_word(CMD_POW, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_POW, 1'b1, 32'h0000_0002, 32'h0000_0001);

        // Random part; a stretch in the middle runs with no idling on either side.
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            no_idle = (n >= 600 && n < 900);
            cmd  = 2'($urandom_range(3));
            wide = 1'($urandom_range(1));
            a    = pick_operand();
            b    = (cmd == CMD_POW) ? pick_exponent() : pick_operand();
            send_word(cmd, wide, a, b);
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        // Drain, then keep watching for any stray result word before the final check.
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.pending() != 0) begin
            $error("%0d result words never arrived", board.pending());
            board.fail_count++;
        end

        $display("checked %0d result words: %0d add, %0d mul, %0d inverse, %0d power",
                 board.checked, board.cmd_seen[CMD_ADD], board.cmd_seen[CMD_MUL],
                 board.cmd_seen[CMD_INV], board.cmd_seen[CMD_POW]);
        $display("%0d words in GF(2^32), the rest in GF(2^8), gaps on both sides",
                 board.wide_seen);
        if (board.fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
src/gfau_pkg.sv
src/gfau_mul.sv
src/gf2m_field_arith_unit.sv
verif/gf2m_field_arith_unit_tb.sv
